// ----- hdl/bppd_pkg.sv -----
// ----------------------------------------------------------------------------
// bppd_pkg: shared types and constants
// Types and constants for the BMP/PPM streaming image decoder.
// ----------------------------------------------------------------------------
package bppd_pkg;

  localparam int unsigned MaxDim = 16384;
  localparam logic [31:0] MaxFileReset = 32'd134217728;
  localparam logic [16:0] NumCap = 17'd131071;

  typedef enum logic [2:0] {
    PhMagic0  = 3'd0,
    PhMagic1  = 3'd1,
    PhBmpHdr  = 3'd2,
    PhPpmSkip = 3'd3,
    PhPpmDig  = 3'd4,
    PhPixels  = 3'd5,
    PhDone    = 3'd6,
    PhDead    = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    FmtNone = 2'd0,
    FmtBmp  = 2'd1,
    FmtPpm  = 2'd2,
    FmtUnk  = 2'd3
  } fmt_e;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StUnknown = 3'd1;
  localparam logic [2:0] StBadHdr  = 3'd2;
  localparam logic [2:0] StTrunc   = 3'd3;
  localparam logic [2:0] StLarge   = 3'd4;

  // One result as it waits in the queue.
  typedef struct packed {
    logic        is_status;
    logic [14:0] column;
    logic [14:0] row;
    logic [31:0] argb;
    logic [2:0]  status_code;
    logic        last_of_run;
  } result_t;

  localparam int unsigned ResW = $bits(result_t);

endpackage

// ----- hdl/bmp_ppm_image_decoder_top.sv -----
// ----------------------------------------------------------------------------
// bmp_ppm_image_decoder_top: BMP / PPM P6 streaming decoder
// Takes an image file byte by byte and streams XRGB pixels and a status.
// ----------------------------------------------------------------------------
// Usage: feed the file one byte per beat on s_axis (tdata = data byte,
// tlast = final byte of the file). Each byte is parsed in the beat it is
// accepted; a completed pixel and, on the final byte, a status result are
// written into a four-entry queue that drives m_axis. Results are registered
// in the queue before they appear on m_axis.
// Throughput is one byte per cycle; the parser sustains it as long as the
// queue keeps room for two results, so a byte that yields a pixel and a
// status leaves two results in the queue to drain.
// m_axis tuser = is_status. A stalled receiver fills the queue; s_axis_tready
// stays low while fewer than two entries are free. Reset clears the parser and
// the queue and sets max_file_bytes to 134217728. The user writes the config
// channel only while the decoder is idle; the decoder does not enforce this.
// ----------------------------------------------------------------------------
module bmp_ppm_image_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [14:0] column, [29:15] row, [61:30] argb, [64:62] status_code, [71:65] 0
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] is_status
  output logic        m_axis_tlast
);

  logic              fire, room2, w0, w1;
  bppd_pkg::result_t r0, r1, qo;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = room2;
  assign fire          = s_axis_tvalid && room2;

  bppd_parser u_parser (
    .clk_i, .rst_ni,
    .cfg_tvalid_i(cfg_valid_i), .cfg_tdata_i(cfg_data_i),
    .in_fire_i(fire), .byte_i(s_axis_tdata), .eof_i(s_axis_tlast),
    .res0_vld_o(w0), .res0_o(r0), .res1_vld_o(w1), .res1_o(r1)
  );

  bppd_queue u_queue (
    .clk_i, .rst_ni,
    .w0_i(w0), .d0_i(r0), .w1_i(w1), .d1_i(r1),
    .room2_o(room2),
    .out_valid_o(m_axis_tvalid), .out_data_o(qo), .out_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {7'd0, qo.status_code, qo.argb, qo.row, qo.column};
  assign m_axis_tuser = qo.is_status;
  assign m_axis_tlast = qo.last_of_run;

endmodule

// ----- hdl/bppd_parser.sv -----
// ----------------------------------------------------------------------------
// bppd_parser: byte parser front end
// Parses one file byte per beat and produces up to two results per byte.
// ----------------------------------------------------------------------------
module bppd_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_tvalid_i,
  input  logic [31:0]            cfg_tdata_i,
  input  logic                   in_fire_i,
  input  logic [7:0]             byte_i,
  input  logic                   eof_i,
  output logic                   res0_vld_o,
  output bppd_pkg::result_t      res0_o,
  output logic                   res1_vld_o,
  output bppd_pkg::result_t      res1_o
);

  logic [31:0] max_q, max_d;
  logic [31:0] pos_q, pos_d;
  bppd_pkg::fmt_e   fmt_q, fmt_d;
  bppd_pkg::phase_e ph_q, ph_d;
  logic [31:0] off_q, off_d;
  logic [14:0] wid_q, wid_d;
  logic [31:0] hgt_q, hgt_d;
  logic [15:0] bpp_q, bpp_d;
  logic [31:0] cmp_q, cmp_d;
  logic [16:0] acc_q, acc_d;
  logic [1:0]  hni_q, hni_d;
  logic        cmt_q, cmt_d;
  logic [14:0] col_q, col_d;
  logic [14:0] rowc_q, rowc_d;
  logic [16:0] bir_q, bir_d;
  logic [15:0] hold_q, hold_d;
  logic [2:0]  err_q, err_d;
  // Full 32-bit BMP width bytes; only the low 15 bits are kept after checks.
  logic [31:0] bw_q, bw_d;
  // Derived row geometry, computed once at header acceptance; kph counts bytes within a pixel.
  logic [16:0] dlen_q, dlen_d;
  logic [16:0] stride_q, stride_d;
  logic [1:0]  bpb_q, bpb_d;
  logic [1:0]  kph_q, kph_d;

  logic [31:0] hmag;
  assign hmag = hgt_q[31] ? (32'd0 - hgt_q) : hgt_q;

  logic b_dig, b_ws;
  logic [16:0] dval;
  logic [20:0] acc10;
  assign b_dig = (byte_i >= 8'h30) && (byte_i <= 8'h39);
  assign b_ws  = (byte_i == 8'h20) || (byte_i == 8'h09) || (byte_i == 8'h0d) ||
                 (byte_i == 8'h0a);
  assign dval  = {9'd0, byte_i - 8'h30};
  assign acc10 = {acc_q, 3'd0} + {2'd0, acc_q, 1'b0} + {4'd0, dval};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= bppd_pkg::MaxFileReset;
      pos_q <= '0; fmt_q <= bppd_pkg::FmtNone; ph_q <= bppd_pkg::PhMagic0;
      off_q <= '0; wid_q <= '0; hgt_q <= '0; bpp_q <= '0; cmp_q <= '0;
      acc_q <= '0; hni_q <= '0; cmt_q <= '0; col_q <= '0; rowc_q <= '0;
      bir_q <= '0; hold_q <= '0; err_q <= '0; bw_q <= '0;
      dlen_q <= '0; stride_q <= '0; bpb_q <= '0; kph_q <= '0;
    end else begin
      max_q <= max_d;
      pos_q <= pos_d; fmt_q <= fmt_d; ph_q <= ph_d; off_q <= off_d;
      wid_q <= wid_d; hgt_q <= hgt_d; bpp_q <= bpp_d; cmp_q <= cmp_d;
      acc_q <= acc_d; hni_q <= hni_d; cmt_q <= cmt_d; col_q <= col_d;
      rowc_q <= rowc_d; bir_q <= bir_d; hold_q <= hold_d; err_q <= err_d;
      bw_q <= bw_d; dlen_q <= dlen_d; stride_q <= stride_d;
      bpb_q <= bpb_d; kph_q <= kph_d;
    end
  end

  always_comb begin
    logic        skip_go;
    logic        start_px;
    logic [2:0]  fcode;
    logic        failed;
    logic [7:0]  first_b, mid_b;
    logic [14:0] prow;
    logic [16:0] dl;
    logic [16:0] bir_n;
    logic [2:0]  code;
    logic        px;
    skip_go  = 1'b0;
    start_px = 1'b0;
    failed   = 1'b0;
    fcode    = bppd_pkg::StOk;
    first_b  = hold_q[7:0];
    mid_b    = hold_q[15:8];
    prow     = '0;
    dl       = '0;
    bir_n    = '0;
    code     = bppd_pkg::StOk;
    px       = 1'b0;

    max_d = cfg_tvalid_i ? cfg_tdata_i : max_q;
    pos_d = pos_q; fmt_d = fmt_q; ph_d = ph_q; off_d = off_q; wid_d = wid_q;
    hgt_d = hgt_q; bpp_d = bpp_q; cmp_d = cmp_q; acc_d = acc_q; hni_d = hni_q;
    cmt_d = cmt_q; col_d = col_q; rowc_d = rowc_q; bir_d = bir_q;
    hold_d = hold_q; err_d = err_q; bw_d = bw_q; dlen_d = dlen_q;
    stride_d = stride_q; bpb_d = bpb_q; kph_d = kph_q;
    res0_vld_o = 1'b0;
    res1_vld_o = 1'b0;
    res0_o = '0;
    res1_o = '0;

    if (in_fire_i) begin
      if ({1'b0, pos_q} + 33'd1 > {1'b0, max_q}) begin
        err_d = bppd_pkg::StLarge;
        ph_d  = bppd_pkg::PhDead;
      end else begin
        unique case (ph_q)
          bppd_pkg::PhMagic0: begin
            hold_d = {8'd0, byte_i};
            ph_d   = bppd_pkg::PhMagic1;
          end
          bppd_pkg::PhMagic1: begin
            if (hold_q[7:0] == 8'h42 && byte_i == 8'h4d) begin
              fmt_d = bppd_pkg::FmtBmp;
              ph_d  = bppd_pkg::PhBmpHdr;
            end else if (hold_q[7:0] == 8'h50 && byte_i == 8'h36) begin
              fmt_d = bppd_pkg::FmtPpm;
              ph_d  = bppd_pkg::PhPpmSkip;
            end else begin
              fmt_d = bppd_pkg::FmtUnk;
              failed = 1'b1; fcode = bppd_pkg::StUnknown;
            end
          end
          bppd_pkg::PhBmpHdr: begin
            case (pos_q[5:0])
              6'd10: off_d[7:0]   = byte_i;
              6'd11: off_d[15:8]  = byte_i;
              6'd12: off_d[23:16] = byte_i;
              6'd13: off_d[31:24] = byte_i;
              6'd18: bw_d[7:0]    = byte_i;
              6'd19: bw_d[15:8]   = byte_i;
              6'd20: bw_d[23:16]  = byte_i;
              6'd21: bw_d[31:24]  = byte_i;
              6'd22: hgt_d[7:0]   = byte_i;
              6'd23: hgt_d[15:8]  = byte_i;
              6'd24: hgt_d[23:16] = byte_i;
              6'd25: hgt_d[31:24] = byte_i;
              6'd28: bpp_d[7:0]   = byte_i;
              6'd29: bpp_d[15:8]  = byte_i;
              6'd30: cmp_d[7:0]   = byte_i;
              6'd31: cmp_d[15:8]  = byte_i;
              6'd32: cmp_d[23:16] = byte_i;
              6'd33: cmp_d[31:24] = byte_i;
              default: ;
            endcase
            if (pos_q == 32'd53) begin
              if (bw_q == 32'd0 || bw_q > 32'(bppd_pkg::MaxDim) || hgt_q == 32'd0 ||
                  hmag > 32'(bppd_pkg::MaxDim) ||
                  (bpp_q != 16'd24 && bpp_q != 16'd32) ||
                  (cmp_q != 32'd0 && cmp_q != 32'd3) || off_q < 32'd54) begin
                failed = 1'b1; fcode = bppd_pkg::StBadHdr;
              end else begin
                wid_d = bw_q[14:0];
                start_px = 1'b1;
              end
            end
          end
          bppd_pkg::PhPpmSkip: skip_go = 1'b1;
          bppd_pkg::PhPpmDig: begin
            if (b_dig) begin
              acc_d = (acc10 > {4'd0, bppd_pkg::NumCap}) ? bppd_pkg::NumCap
                                                         : acc10[16:0];
            end else if (hni_q != 2'd2) begin
              if (acc_q == 17'd0 || acc_q > 17'(bppd_pkg::MaxDim)) begin
                failed = 1'b1; fcode = bppd_pkg::StBadHdr;
              end else begin
                if (hni_q == 2'd0) wid_d = acc_q[14:0];
                else hgt_d = {15'd0, acc_q};
                hni_d = hni_q + 2'd1;
                ph_d  = bppd_pkg::PhPpmSkip;
                skip_go = 1'b1;
              end
            end else if (acc_q != 17'd255) begin
              failed = 1'b1; fcode = bppd_pkg::StBadHdr;
            end else begin
              bpp_d = 16'd24;
              start_px = 1'b1;
            end
          end
          bppd_pkg::PhPixels: begin
            if (!(fmt_q == bppd_pkg::FmtBmp && pos_q < off_q)) begin
              px = 1'b1;
              if (bir_q < dlen_q) begin
                if (kph_q == 2'd0) begin
                  hold_d = {8'd0, byte_i};
                end else if (kph_q == 2'd1) begin
                  hold_d = {byte_i, hold_q[7:0]};
                end else if (kph_q == 2'd2) begin
                  prow = rowc_q;
                  if (fmt_q == bppd_pkg::FmtBmp && !hgt_q[31])
                    prow = 15'(hmag - 32'd1 - {17'd0, rowc_q});
                  res0_vld_o = 1'b1;
                  res0_o.column = col_q;
                  res0_o.row = prow;
                  res0_o.argb = (fmt_q == bppd_pkg::FmtBmp)
                    ? {8'hff, byte_i, mid_b, first_b}
                    : {8'hff, first_b, mid_b, byte_i};
                  col_d = col_q + 15'd1;
                end
                kph_d = (kph_q == bpb_q) ? 2'd0 : kph_q + 2'd1;
              end
              bir_n = bir_q + 17'd1;
              bir_d = bir_n;
              if (bir_n >= stride_q) begin
                bir_d = '0;
                col_d = '0;
                kph_d = '0;
                rowc_d = rowc_q + 15'd1;
                if ({17'd0, rowc_q} + 32'd1 >= hmag) ph_d = bppd_pkg::PhDone;
              end
            end
          end
          default: ;
        endcase
      end

      if (skip_go) begin
        if (cmt_q) begin
          if (byte_i == 8'h0a) cmt_d = 1'b0;
        end else if (b_ws) begin
        end else if (byte_i == 8'h23) begin
          cmt_d = 1'b1;
        end else if (b_dig) begin
          acc_d = dval;
          ph_d  = bppd_pkg::PhPpmDig;
        end else begin
          failed = 1'b1; fcode = bppd_pkg::StBadHdr;
        end
      end
      if (failed) begin
        err_d = fcode;
        ph_d  = bppd_pkg::PhDead;
      end
      if (start_px) begin
        hni_d = 2'd3;
        col_d = '0; rowc_d = '0; bir_d = '0; hold_d = '0; kph_d = '0;
        ph_d = bppd_pkg::PhPixels;
        // Bytes per pixel less one: 3 at 32 bpp, else 2.
        bpb_d = (fmt_q == bppd_pkg::FmtBmp && bpp_q == 16'd32) ? 2'd3 : 2'd2;
        dl = (bpb_d == 2'd3) ? {wid_d, 2'b00} : ({2'd0, wid_d} + {1'b0, wid_d, 1'b0});
        dlen_d = dl;
        stride_d = (fmt_q == bppd_pkg::FmtBmp) ? ((dl + 17'd3) & ~17'd3) : dl;
      end
      if (pos_q != 32'hffffffff) pos_d = pos_q + 32'd1;

      if (eof_i) begin
        if (err_d != 3'd0) code = err_d;
        else if (ph_d == bppd_pkg::PhMagic0 || ph_d == bppd_pkg::PhMagic1)
          code = bppd_pkg::StUnknown;
        else if (ph_d != bppd_pkg::PhDone) code = bppd_pkg::StTrunc;
        else code = bppd_pkg::StOk;
        res1_vld_o = 1'b1;
        res1_o.is_status = 1'b1;
        res1_o.status_code = code;
        res1_o.last_of_run = 1'b1;
        if (hni_d == 2'd3) begin
          res1_o.column = wid_d;
          res1_o.row = hgt_d[31] ? 15'(32'd0 - hgt_d) : hgt_d[14:0];
        end
        pos_d = '0; fmt_d = bppd_pkg::FmtNone; ph_d = bppd_pkg::PhMagic0;
        off_d = '0; wid_d = '0; hgt_d = '0; bpp_d = '0; cmp_d = '0; acc_d = '0;
        hni_d = '0; cmt_d = '0; col_d = '0; rowc_d = '0; bir_d = '0;
        hold_d = '0; err_d = '0; bw_d = '0; kph_d = '0;
      end else begin
        res0_o.last_of_run = 1'b1;
      end
      if (px && !res0_vld_o) res0_o = '0;
    end
  end

`ifndef SYNTHESIS
  a_one_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res1_vld_o |-> (in_fire_i && eof_i)) else $error("status without eof");
  a_pixel_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res0_vld_o |-> (res0_o.status_code == bppd_pkg::StOk && !res0_o.is_status))
    else $error("pixel carries status");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_i && eof_i) |=> (pos_q == 32'd0 && err_q == 3'd0))
    else $error("file state not cleared");
`endif

endmodule

// ----- hdl/bppd_queue.sv -----
// ----------------------------------------------------------------------------
// bppd_queue: result queue
// Four-entry queue between the parser and the output port; takes up to two
// results per beat and gives one per beat.
// ----------------------------------------------------------------------------
module bppd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 w0_i,
  input  bppd_pkg::result_t    d0_i,
  input  logic                 w1_i,
  input  bppd_pkg::result_t    d1_i,
  output logic                 room2_o,
  output logic                 out_valid_o,
  output bppd_pkg::result_t    out_data_o,
  input  logic                 out_ready_i
);

  bppd_pkg::result_t mem_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] cnt_q;
  logic [1:0] nw;
  logic       pop;

  assign nw  = {1'b0, w0_i} + {1'b0, w1_i};
  assign pop = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != 3'd0;
  assign out_data_o  = mem_q[rd_q];
  assign room2_o     = cnt_q <= 3'd2;

  always_ff @(posedge clk_i) begin
    if (w0_i) mem_q[wr_q] <= d0_i;
    if (w1_i) mem_q[wr_q + {1'b0, w0_i}] <= d1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0; wr_q <= '0; cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + nw;
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_q + {1'b0, nw} - {2'd0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("queue overflow");
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nw != 2'd0) |-> room2_o) else $error("write without room");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nw == 2'd0 && !pop) |=> $stable(cnt_q)) else $error("count drift");
`endif

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for the BMP / PPM P6 image decoder
// Streams generated BMP and PPM files, well formed and broken, through the
// decoder, predicts every pixel and status beat and checks each field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldLen = 300;

  typedef struct {
    logic [7:0] data;
    logic       eof;
  } file_byte_t;

  typedef struct {
    logic        is_status;
    logic [14:0] column;
    logic [14:0] row;
    logic [31:0] argb;
    logic [2:0]  code;
    logic        last;
  } pix_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  bmp_ppm_image_decoder_top uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state, one copy of the decoder's per-file state.
  logic [31:0] max_bytes = bppd_pkg::MaxFileReset;
  logic [31:0] pos, px_off, raw_h, compr, hold;
  logic [31:0] width_r, acc, bpp_r, col_cnt, row_cnt, in_row;
  logic [2:0]  err;
  bppd_pkg::phase_e phase;
  bppd_pkg::fmt_e   fmt;
  int          hdr_idx;
  logic        in_cmt;

  file_byte_t  byte_q[$];
  pix_t        pixel_q[$];
  int          errors = 0, n_files = 0, n_pix = 0, n_stat = 0, n_bytes = 0;
  bit          quiet_rx = 1'b0, hold_req = 1'b0, sender_pause = 1'b0;
  int          idle_cnt = 0;

  // Whether the beat on s_axis was taken at the last rising edge.
  logic s_axis_tready_q = 1'b0;
  int rx_idle = 0, hold_cnt = 0, stall_cycles = 0;

  function automatic void clear_file();
    pos = 0; fmt = bppd_pkg::FmtNone; phase = bppd_pkg::PhMagic0; px_off = 0;
    width_r = 0; raw_h = 0; bpp_r = 0; compr = 0; acc = 0; hdr_idx = 0;
    in_cmt = 1'b0; col_cnt = 0; row_cnt = 0; in_row = 0; hold = 0;
    err = bppd_pkg::StOk;
  endfunction

  function automatic logic [31:0] h_mag();
    return raw_h[31] ? 32'd0 - raw_h : raw_h;
  endfunction

  function automatic void kill(logic [2:0] c);
    err = c;
    phase = bppd_pkg::PhDead;
  endfunction

  function automatic void begin_pixels();
    hdr_idx = 3; col_cnt = 0; row_cnt = 0; in_row = 0; hold = 0;
    phase = bppd_pkg::PhPixels;
  endfunction

  function automatic bit is_ws(logic [7:0] b);
    return b == " " || b == "\t" || b == "\r" || b == "\n";
  endfunction

  function automatic void skip_byte(logic [7:0] b);
    if (in_cmt) begin
      if (b == "\n") in_cmt = 1'b0;
    end else if (is_ws(b)) begin
    end else if (b == "#") begin
      in_cmt = 1'b1;
    end else if (b >= "0" && b <= "9") begin
      acc = 32'(b) - 32'd48;
      phase = bppd_pkg::PhPpmDig;
    end else begin
      kill(bppd_pkg::StBadHdr);
    end
  endfunction

  function automatic void push_pix(logic st, logic [31:0] c, logic [31:0] r,
                                   logic [31:0] argb, logic [2:0] code);
    pix_t p;
    p.is_status = st; p.column = c[14:0]; p.row = r[14:0];
    p.argb = argb; p.code = code; p.last = 1'b0;
    pixel_q.push_back(p);
  endfunction

  // Works out the beats caused by one accepted file byte.
  function automatic void decode_byte(logic [7:0] b, logic eof);
    int n;
    logic [31:0] v, bpb, dlen, stride, k, argb, r;
    logic [2:0] code;
    n = 0;
    if ({32'd0, pos} + 64'd1 > {32'd0, max_bytes}) kill(bppd_pkg::StLarge);
    case (phase)
      bppd_pkg::PhMagic0: begin
        hold = 32'(b); phase = bppd_pkg::PhMagic1;
      end
      bppd_pkg::PhMagic1: begin
        if (hold[7:0] == "B" && b == "M") begin
          fmt = bppd_pkg::FmtBmp; phase = bppd_pkg::PhBmpHdr;
        end else if (hold[7:0] == "P" && b == "6") begin
          fmt = bppd_pkg::FmtPpm; phase = bppd_pkg::PhPpmSkip; hdr_idx = 0;
          in_cmt = 1'b0;
        end else begin
          fmt = bppd_pkg::FmtUnk; kill(bppd_pkg::StUnknown);
        end
      end
      bppd_pkg::PhBmpHdr: begin
        if (pos >= 10 && pos <= 13) px_off |= 32'(b) << (8 * (pos - 10));
        else if (pos >= 18 && pos <= 21) width_r |= 32'(b) << (8 * (pos - 18));
        else if (pos >= 22 && pos <= 25) raw_h |= 32'(b) << (8 * (pos - 22));
        else if (pos >= 28 && pos <= 29) bpp_r |= 32'(b) << (8 * (pos - 28));
        else if (pos >= 30 && pos <= 33) compr |= 32'(b) << (8 * (pos - 30));
        if (pos == 53) begin
          if (width_r == 0 || width_r > bppd_pkg::MaxDim || raw_h == 0 ||
              h_mag() > bppd_pkg::MaxDim ||
              (bpp_r != 24 && bpp_r != 32) || (compr != 0 && compr != 3) ||
              px_off < 54) kill(bppd_pkg::StBadHdr);
          else begin_pixels();
        end
      end
      bppd_pkg::PhPpmSkip: skip_byte(b);
      bppd_pkg::PhPpmDig: begin
        v = acc;
        if (b >= "0" && b <= "9") begin
          v = v * 32'd10 + (32'(b) - 32'd48);
          acc = (v > 32'(bppd_pkg::NumCap)) ? 32'(bppd_pkg::NumCap) : v;
        end else if (hdr_idx < 2) begin
          if (v == 0 || v > bppd_pkg::MaxDim) kill(bppd_pkg::StBadHdr);
          else begin
            if (hdr_idx == 0) width_r = v;
            else raw_h = v;
            hdr_idx++;
            phase = bppd_pkg::PhPpmSkip;
            skip_byte(b);
          end
        end else if (v != 255) begin
          kill(bppd_pkg::StBadHdr);
        end else begin
          bpp_r = 24;
          begin_pixels();
        end
      end
      bppd_pkg::PhPixels: begin
        if (!(fmt == bppd_pkg::FmtBmp && pos < px_off)) begin
          bpb = bpp_r / 32'd8;
          if (bpb == 0) bpb = 3;
          dlen = width_r * bpb;
          stride = fmt == bppd_pkg::FmtBmp ? ((dlen + 32'd3) & ~32'd3) : dlen;
          if (in_row < dlen) begin
            k = in_row % bpb;
            if (k == 0) hold = 32'(b);
            else if (k == 1) hold = (hold & 32'hFF) | (32'(b) << 8);
            else if (k == 2) begin
              if (fmt == bppd_pkg::FmtBmp)
                argb = 32'hFF000000 | (32'(b) << 16) | (hold & 32'hFFFF);
              else
                argb = 32'hFF000000 | ((hold & 32'hFF) << 16) | (hold & 32'hFF00)
                       | 32'(b);
              r = row_cnt;
              if (fmt == bppd_pkg::FmtBmp && !raw_h[31]) r = h_mag() - 32'd1 - row_cnt;
              push_pix(1'b0, col_cnt, r, argb, bppd_pkg::StOk);
              col_cnt++;
              n = 1;
            end
          end
          in_row++;
          if (in_row >= stride) begin
            in_row = 0; col_cnt = 0; row_cnt++;
            if (row_cnt >= h_mag()) phase = bppd_pkg::PhDone;
          end
        end
      end
      default: ;
    endcase
    if (pos != 32'hFFFFFFFF) pos++;
    if (eof) begin
      if (err != 3'd0) code = err;
      else if (phase == bppd_pkg::PhMagic0 || phase == bppd_pkg::PhMagic1)
        code = bppd_pkg::StUnknown;
      else if (phase != bppd_pkg::PhDone) code = bppd_pkg::StTrunc;
      else code = bppd_pkg::StOk;
      if (hdr_idx == 3) push_pix(1'b1, width_r, h_mag(), 32'd0, code);
      else push_pix(1'b1, 32'd0, 32'd0, 32'd0, code);
      n++;
      clear_file();
    end
    if (n > 0) pixel_q[$].last = 1'b1;
  endfunction

  // Driver: the byte queue feeds s_axis, with random idle bursts.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready_q) begin
        if (idle_cnt > 0) begin
          idle_cnt <= idle_cnt - 1;
          s_axis_tvalid <= 1'b0;
        end else if (byte_q.size() > 0 && !sender_pause) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= byte_q[0].data;
          s_axis_tlast <= byte_q[0].eof;
          byte_q.pop_front();
          if (!quiet_rx && $urandom_range(0, 9) == 0) idle_cnt <= $urandom_range(1, 7);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tlast);
    if (m_axis_tvalid && m_axis_tready) begin
      pix_t e, a;
      a.is_status = m_axis_tuser; a.column = m_axis_tdata[14:0];
      a.row = m_axis_tdata[29:15]; a.argb = m_axis_tdata[61:30];
      a.code = m_axis_tdata[64:62]; a.last = m_axis_tlast;
      if (a.is_status) n_stat++;
      else n_pix++;
      if (pixel_q.size() == 0) begin
        $error("unexpected beat: %p", a);
        errors++;
      end else begin
        e = pixel_q.pop_front();
        if (e.is_status !== a.is_status) begin
          $error("is_status: exp %0d got %0d", e.is_status, a.is_status); errors++;
        end
        if (e.column !== a.column) begin
          $error("column: exp %0d got %0d", e.column, a.column); errors++;
        end
        if (e.row !== a.row) begin
          $error("row: exp %0d got %0d", e.row, a.row); errors++;
        end
        if (e.argb !== a.argb) begin
          $error("argb: exp %h got %h", e.argb, a.argb); errors++;
        end
        if (e.code !== a.code) begin
          $error("status_code: exp %0d got %0d", e.code, a.code); errors++;
        end
        if (e.last !== a.last) begin
          $error("last_of_run: exp %0d got %0d", e.last, a.last); errors++;
        end
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 5000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold when hold_req is set.
  always @(negedge clk_i) begin
    if (hold_req && hold_cnt < HoldLen) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else if (rx_idle > 0) begin
      rx_idle <= rx_idle - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet_rx && $urandom_range(0, 7) == 0) begin
      rx_idle <= $urandom_range(1, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  function automatic void add_byte(logic [7:0] d, logic eof = 1'b0);
    file_byte_t f;
    f.data = d; f.eof = eof;
    byte_q.push_back(f);
    n_bytes++;
  endfunction

  function automatic void add_le(logic [31:0] v, int nb);
    for (int i = 0; i < nb; i++) add_byte(v[8*i +: 8]);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void end_file();
    byte_q[$].eof = 1'b1;
    n_files++;
  endfunction

  // A BMP file; cut <= 0 keeps it whole, otherwise it stops after cut bytes.
  function automatic void add_bmp(int w, int h, int bits, int cmp, int off, int cut,
                                  int extra);
    int total, sz, stride;
    file_byte_t f;
    sz = byte_q.size();
    add_text("BM"); add_le(0, 4); add_le(0, 4); add_le(off, 4); add_le(40, 4);
    add_le(w, 4); add_le(h, 4); add_le(1, 2); add_le(bits, 2); add_le(cmp, 4);
    add_le(0, 20);
    for (int i = 54; i < off; i++) add_byte(8'($urandom));
    stride = ((w * bits / 8) + 3) & ~3;
    if (h < 0) h = -h;
    if (h <= 16 && w <= 16 && w > 0)
      for (int i = 0; i < stride * h; i++) add_byte(8'($urandom));
    for (int i = 0; i < extra; i++) add_byte(8'($urandom));
    total = byte_q.size() - sz;
    if (cut > 0 && cut < total)
      for (int i = cut; i < total; i++) begin
        f = byte_q.pop_back();
        n_bytes--;
      end
    end_file();
  endfunction

  function automatic void add_ppm(int w, int h, int mx, bit cmt, int cut);
    int sz, total;
    file_byte_t f;
    sz = byte_q.size();
    add_text("P6");
    if (cmt) add_text(" # note\n\t"); else add_text("\n");
    add_text($sformatf("%0d %0d\r\n%0d", w, h, mx));
    add_byte(" ");
    if (w <= 16 && h <= 16) for (int i = 0; i < 3 * w * h; i++) add_byte(8'($urandom));
    total = byte_q.size() - sz;
    if (cut > 0 && cut < total)
      for (int i = cut; i < total; i++) begin
        f = byte_q.pop_back();
        n_bytes--;
      end
    end_file();
  endfunction

  function automatic void add_random_file();
    int pick = $urandom_range(0, 19);
    int w = $urandom_range(1, 6), h = $urandom_range(1, 5);
    if (pick < 7)
      add_bmp(w, $urandom_range(0, 1) ? h : -h, $urandom_range(0, 1) ? 24 : 32,
              $urandom_range(0, 1) ? 0 : 3, 54 + $urandom_range(0, 3),
              $urandom_range(0, 4) == 0 ? $urandom_range(1, 70) : -1,
              $urandom_range(0, 2));
    else if (pick < 14)
      add_ppm(w, h, 255, 1'($urandom_range(0, 1)),
              $urandom_range(0, 4) == 0 ? $urandom_range(1, 40) : -1);
    else if (pick < 16)
      add_bmp(w, h, $urandom_range(0, 40), $urandom_range(0, 4), $urandom_range(40, 60),
              -1, 0);
    else if (pick < 18)
      add_ppm($urandom_range(0, 3), h, $urandom_range(250, 256), 1'b0, -1);
    else begin
      int n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) add_byte(8'($urandom));
      end_file();
    end
  endfunction

  task automatic drain();
    while (byte_q.size() > 0 || s_axis_tvalid || pixel_q.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [31:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    max_bytes = v;
  endtask

  initial begin
    int sz0;
    clear_file();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: both formats, top-down and bottom-up, every status but StLarge.
    add_bmp(2, 2, 24, 0, 54, -1, 2);
    add_bmp(1, -2, 32, 3, 56, -1, 0);
    add_bmp(16384, 1, 24, 0, 54, 60, 0);
    add_bmp(16385, 1, 24, 0, 54, -1, 0);
    add_bmp(2, 2, 24, 0, 53, -1, 0);
    add_bmp(2, 2, 16, 1, 54, -1, 0);
    add_ppm(3, 2, 255, 1'b1, -1);
    add_ppm(2, 2, 255, 1'b0, 20);
    add_ppm(16384, 16384, 255, 1'b0, -1);
    add_ppm(0, 2, 255, 1'b0, -1);
    add_ppm(2, 2, 999999, 1'b0, -1);
    add_text("P6 2x"); end_file();
    add_byte(8'hFF, 1'b1); n_files++;
    add_byte(8'h00); add_byte(8'h00, 1'b1); n_files++;
    drain();

    // Register extremes: tiny limits and the all-ones limit; the default returns after the hold.
    write_cfg(32'd1);
    add_ppm(1, 1, 255, 1'b0, -1);
    add_byte(8'h42, 1'b1); n_files++;
    drain();
    write_cfg(32'd30);
    add_bmp(2, 2, 24, 0, 54, -1, 0);
    add_ppm(2, 1, 255, 1'b0, -1);
    drain();
    write_cfg(32'hFFFFFFFF);
    for (int i = 0; i < 2; i++) add_random_file();
    drain();

    // Long receiver hold while the sender keeps offering bytes.
    hold_req = 1'b1;
    for (int i = 0; i < 2; i++) add_ppm(4, 4, 255, 1'b0, -1);
    wait (hold_cnt == HoldLen);
    hold_req = 1'b0;
    drain();
    write_cfg(bppd_pkg::MaxFileReset);

    // Sender stops part way through a file until every result is out.
    add_random_file();
    sz0 = byte_q.size();
    @(posedge clk_i iff byte_q.size() <= sz0 / 2);
    sender_pause = 1'b1;
    while (pixel_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    sender_pause = 1'b0;

    while (n_bytes < 940) begin
      if (n_bytes >= 860) quiet_rx = 1'b1;
      add_random_file();
      if (byte_q.size() > 60) @(posedge clk_i iff byte_q.size() < 30);
    end
    quiet_rx = 1'b1;
    drain();
    $display("Checked %0d files (%0d bytes): %0d pixel beats and %0d status beats.",
             n_files, n_bytes, n_pix, n_stat);
    $display("Covered BMP 24/32 bpp both row orders, PPM with comments, bad headers,");
    $display("truncation, size limit and unknown formats.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
